// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication into the next cycle, quiet while reset is held
`define MLP_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// implication into the next cycle that also runs across reset
`define MLP_ASSERT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/mlp_pkg.sv =====
`default_nettype none
package mlp_pkg;

  localparam int DATA_W  = 16;
  localparam int FRAC_W  = 12;
  localparam int ACC_W   = 40;
  localparam int IDX_W   = 6;
  localparam int WIDTH_W = 7;
  localparam int MAX_W   = 64;
  localparam int ELU_N   = 256;

  localparam logic [1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [1:0] CMD_BIAS    = 2'd1;
  localparam logic [1:0] CMD_FEATURE = 2'd2;

  localparam logic [2:0] CFG_IN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HID_ONE   = 3'd1;
  localparam logic [2:0] CFG_HID_TWO   = 3'd2;
  localparam logic [2:0] CFG_HID_THREE = 3'd3;
  localparam logic [2:0] CFG_OUT_WIDTH = 3'd4;

  localparam logic [1:0] LAST_LAYER = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic clr;
    logic load;
  } mac_ctl_t;

  typedef data_t elu_tab_t [ELU_N];

  // e^(-n/32) by repeated rounded q32 products, then minus one in q4.12
  function automatic elu_tab_t elu_gen();
    logic [63:0] p;
    logic [63:0] q;
    elu_tab_t    t;
    p = 64'h1_0000_0000;
    for (int k = ELU_N - 1; k >= 0; k--) begin
      p = (p * 64'd4162825044 + 64'h8000_0000) >> 32;
      q = (p + (64'd1 << (31 - FRAC_W))) >> (32 - FRAC_W);
      t[k] = $signed(q[DATA_W-1:0]) - data_t'(1 << FRAC_W);
    end
    return t;
  endfunction

  localparam elu_tab_t ELU_TABLE = elu_gen();

endpackage
`default_nettype wire

// ===== rtl/mlp_mac.sv =====
`default_nettype none
module mlp_mac (
  input  logic             clk,
  input  logic             rst_n,
  input  mlp_pkg::mac_ctl_t ctl,
  input  mlp_pkg::data_t   op_a,
  input  mlp_pkg::data_t   op_b,
  output mlp_pkg::acc_t    acc,
  output logic             busy
);
  import mlp_pkg::*;

  logic signed [2*DATA_W-1:0] prod_r;
  logic                       prod_v_r;
  acc_t                       acc_r;
  acc_t                       acc_nxt;
  logic signed [ACC_W:0]      sum;

  assign sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(prod_r);

  // saturate on signed overflow of the extended sum
  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= ctl.load;
      if (ctl.clr) begin
        acc_r <= '0;
      end else if (prod_v_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;
endmodule
`default_nettype wire

// ===== rtl/mlp_post.sv =====
`default_nettype none
module mlp_post (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic           hidden,
  input  mlp_pkg::acc_t  acc,
  output mlp_pkg::data_t y,
  output logic           done
);
  import mlp_pkg::*;

  localparam int SH_W = ACC_W + 1 - FRAC_W;

  logic signed [ACC_W:0] rnd;
  logic signed [SH_W-1:0] sh;
  data_t sat;
  data_t y1_r;
  logic  v1_r;
  logic  hid1_r;
  data_t y_r;
  logic  done_r;

  // round half up, then floor shift
  assign rnd = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_W - 1));
  assign sh  = rnd[ACC_W:FRAC_W];

  always_comb begin
    if (sh > SH_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (sh < -SH_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    y1_r   <= sat;
    hid1_r <= hidden;
    if (v1_r) begin
      // negative value: table index is (y + 8.0) in steps of 1/32
      if (hid1_r && y1_r[DATA_W-1]) begin
        y_r <= ELU_TABLE[y1_r[DATA_W-2:DATA_W-9]];
      end else begin
        y_r <= y1_r;
      end
    end
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= go;
      done_r <= v1_r;
    end
  end

  assign y    = y_r;
  assign done = done_r;
endmodule
`default_nettype wire

// ===== rtl/mlp_elu_inference.sv =====
`default_nettype none
// four-layer dense network with elu on the hidden layers, q4.12 data
// input channel (in_*): one transfer per command. weight and bias loads
// and non-final features are written in the transfer cycle and the block
// stays ready. a feature transfer with in_tlast set also starts a pass.
// during a pass in_tready is low. each neuron of a layer with n inputs
// issues n products plus the bias on the single shared multiplier, then
// drains the multiplier pipeline and goes through rounding, activation
// and write-back.
// result channel (out_*): one transfer per output neuron, out_tlast on the
// last one. the result sits in an output register; a stalled receiver
// stalls the pass before the next output neuron is stored.
// configuration (cfg_*): always ready, five 7-bit width registers, to be
// written only while no pass runs.
// reset: widths return to 17/64/64/64/4, the input vector reads as zero,
// no result is pending. weights and biases must be loaded before use.
module mlp_elu_inference (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[1:0], layer_sel[3:2], row_index[9:4], col_index[15:10],
  // data_value[31:16]
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,   // final_feature
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_index[5:0], out_value[21:6], zero fill [23:22]
  output logic [23:0] out_tdata,
  output logic        out_tlast,  // out_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import mlp_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_MAC       = 3'd1;
  localparam logic [2:0] ST_POST_GO   = 3'd2;
  localparam logic [2:0] ST_POST_WAIT = 3'd3;
  localparam logic [2:0] ST_STORE     = 3'd4;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] v);
    if (v == '0) begin
      return WIDTH_W'(1);
    end else if (v > WIDTH_W'(MAX_W)) begin
      return WIDTH_W'(MAX_W);
    end else begin
      return v;
    end
  endfunction

  logic [1:0]       in_cmd;
  logic [1:0]       in_sel;
  logic [IDX_W-1:0] in_row;
  logic [IDX_W-1:0] in_col;
  data_t            in_data;
  logic             in_xfer;

  assign in_cmd  = in_tdata[1:0];
  assign in_sel  = in_tdata[3:2];
  assign in_row  = in_tdata[9:4];
  assign in_col  = in_tdata[15:10];
  assign in_data = in_tdata[31:16];
  assign in_xfer = in_tvalid & in_tready;

  logic [WIDTH_W-1:0] cfg_r [5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[CFG_IN_WIDTH]  <= 7'd17;
      cfg_r[CFG_HID_ONE]   <= 7'd64;
      cfg_r[CFG_HID_TWO]   <= 7'd64;
      cfg_r[CFG_HID_THREE] <= 7'd64;
      cfg_r[CFG_OUT_WIDTH] <= 7'd4;
    end else if (cfg_valid && cfg_index <= CFG_OUT_WIDTH) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         layer_r, layer_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [WIDTH_W-1:0] i_r, i_nxt;
  logic [WIDTH_W-1:0] nin_r, nin_nxt;
  logic [WIDTH_W-1:0] nout_r, nout_nxt;
  logic               s1_v_r, s1_v_nxt;
  logic               s1_bias_r, s1_bias_nxt;
  logic               out_v_r;
  logic               out_load;
  logic [IDX_W-1:0]   out_idx_r;
  data_t              out_val_r;
  logic               out_last_r;
  logic               act_wr;
  logic               post_go;
  logic               hidden;
  logic               last_neuron;
  logic [WIDTH_W-1:0] next_width;
  logic               mac_clr;
  mac_ctl_t           mac_ctl;
  acc_t               acc;
  logic               mac_busy;
  data_t              post_y;
  logic               post_done;

  data_t weight_mem [4*MAX_W*MAX_W];
  data_t bias_mem [4*MAX_W];
  data_t in_mem [MAX_W];
  data_t wa_mem [MAX_W];
  data_t wb_mem [MAX_W];
  logic [MAX_W-1:0] in_vld_r;
  data_t w_q_r;
  data_t b_q_r;
  data_t in_q_r;
  logic  in_qv_r;
  data_t wa_q_r;
  data_t wb_q_r;
  data_t x_q;
  data_t op_a;
  data_t op_b;

  // store writes from loads
  always_ff @(posedge clk) begin
    if (in_xfer && in_cmd == CMD_WEIGHT) begin
      weight_mem[{in_sel, in_row, in_col}] <= in_data;
    end
    w_q_r <= weight_mem[{layer_r, i_r[IDX_W-1:0], j_r}];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_cmd == CMD_BIAS) begin
      bias_mem[{in_sel, in_col}] <= in_data;
    end
    b_q_r <= bias_mem[{layer_r, j_r}];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_cmd == CMD_FEATURE) begin
      in_mem[in_col] <= in_data;
    end
    in_q_r <= in_mem[i_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= '0;
      in_qv_r  <= 1'b0;
    end else begin
      if (in_xfer && in_cmd == CMD_FEATURE) begin
        in_vld_r[in_col] <= 1'b1;
      end
      in_qv_r <= in_vld_r[i_r[IDX_W-1:0]];
    end
  end

  // hidden results ping-pong: layer 0 and 2 write a, layer 1 writes b
  always_ff @(posedge clk) begin
    if (act_wr && !layer_r[0]) begin
      wa_mem[j_r] <= post_y;
    end
    wa_q_r <= wa_mem[i_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (act_wr && layer_r[0]) begin
      wb_mem[j_r] <= post_y;
    end
    wb_q_r <= wb_mem[i_r[IDX_W-1:0]];
  end

  always_comb begin
    if (layer_r == 2'd0) begin
      x_q = in_qv_r ? in_q_r : '0;
    end else if (layer_r[0]) begin
      x_q = wa_q_r;
    end else begin
      x_q = wb_q_r;
    end
  end

  // bias enters the accumulator as bias * 1.0
  assign op_a = s1_bias_r ? b_q_r : x_q;
  assign op_b = s1_bias_r ? data_t'(1 << FRAC_W) : w_q_r;

  assign hidden      = (layer_r != LAST_LAYER);
  assign last_neuron = ({1'b0, j_r} + WIDTH_W'(1)) == nout_r;

  always_comb begin
    case (layer_r)
      2'd0:    next_width = eff_width(cfg_r[CFG_HID_TWO]);
      2'd1:    next_width = eff_width(cfg_r[CFG_HID_THREE]);
      default: next_width = eff_width(cfg_r[CFG_OUT_WIDTH]);
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    layer_nxt   = layer_r;
    j_nxt       = j_r;
    i_nxt       = i_r;
    nin_nxt     = nin_r;
    nout_nxt    = nout_r;
    s1_v_nxt    = 1'b0;
    s1_bias_nxt = 1'b0;
    mac_clr     = 1'b0;
    post_go     = 1'b0;
    act_wr      = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_cmd == CMD_FEATURE && in_tlast) begin
          state_nxt = ST_MAC;
          layer_nxt = 2'd0;
          j_nxt     = '0;
          i_nxt     = '0;
          nin_nxt   = eff_width(cfg_r[CFG_IN_WIDTH]);
          nout_nxt  = eff_width(cfg_r[CFG_HID_ONE]);
          mac_clr   = 1'b1;
        end
      end
      ST_MAC: begin
        if (i_r < nin_r) begin
          s1_v_nxt = 1'b1;
          i_nxt    = i_r + WIDTH_W'(1);
        end else if (i_r == nin_r) begin
          s1_v_nxt    = 1'b1;
          s1_bias_nxt = 1'b1;
          i_nxt       = i_r + WIDTH_W'(1);
        end else if (!s1_v_r && !mac_busy) begin
          state_nxt = ST_POST_GO;
        end
      end
      ST_POST_GO: begin
        post_go   = 1'b1;
        state_nxt = ST_POST_WAIT;
      end
      ST_POST_WAIT: begin
        if (post_done) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        if (hidden || !out_v_r || out_tready) begin
          act_wr   = hidden;
          out_load = !hidden;
          i_nxt    = '0;
          if (!last_neuron) begin
            j_nxt     = j_r + IDX_W'(1);
            mac_clr   = 1'b1;
            state_nxt = ST_MAC;
          end else if (hidden) begin
            layer_nxt = layer_r + 2'd1;
            j_nxt     = '0;
            nin_nxt   = nout_r;
            nout_nxt  = next_width;
            mac_clr   = 1'b1;
            state_nxt = ST_MAC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign mac_ctl = '{clr: mac_clr, load: s1_v_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      layer_r   <= '0;
      j_r       <= '0;
      i_r       <= '0;
      nin_r     <= WIDTH_W'(1);
      nout_r    <= WIDTH_W'(1);
      s1_v_r    <= 1'b0;
      s1_bias_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      layer_r   <= layer_nxt;
      j_r       <= j_nxt;
      i_r       <= i_nxt;
      nin_r     <= nin_nxt;
      nout_r    <= nout_nxt;
      s1_v_r    <= s1_v_nxt;
      s1_bias_r <= s1_bias_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= j_r;
      out_val_r  <= post_y;
      out_last_r <= last_neuron;
    end
  end

  mlp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc),
    .busy  (mac_busy)
  );

  mlp_post u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (post_go),
    .hidden (hidden),
    .acc    (acc),
    .y      (post_y),
    .done   (post_done)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;
endmodule
`default_nettype wire

// ===== rtl/mlp_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module mlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);
  import mlp_pkg::*;

  logic load_xfer;
  logic start_xfer;

  assign load_xfer  = in_tvalid && in_tready && (in_tdata[1:0] != CMD_FEATURE ||
                                                 !in_tlast);
  assign start_xfer = in_tvalid && in_tready && in_tdata[1:0] == CMD_FEATURE && in_tlast;

  `MLP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `MLP_ASSERT_NEXT(a_load_stays_ready, clk, rst_n, load_xfer, in_tready)
  `MLP_ASSERT_NEXT(a_pass_busy, clk, rst_n, start_xfer, !in_tready)
  `MLP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, in_tready && !out_tvalid)
endmodule

bind mlp_elu_inference mlp_checker u_mlp_checker (.*);
`default_nettype wire
